@@ rtl/core/fexp_pkg.sv @@
// shared types and constants of the single-precision exp pipeline
// no dependencies; used by fexp_fma, the top level and the checker

package fexp_pkg;

    // float32 bit patterns of the fixed operands
    localparam logic [31:0] F_BIAS   = 32'h4B40_0000;  // 1.5 * 2^23
    localparam logic [31:0] F_NBIAS  = 32'hCB40_0000;
    localparam logic [31:0] F_ONE    = 32'h3F80_0000;
    localparam logic [31:0] F_ZERO   = 32'h0000_0000;
    localparam logic [31:0] F_LOG2E  = 32'h3FB8_AA3B;
    localparam logic [31:0] F_LN2_HI = 32'hBF31_7200;
    localparam logic [31:0] F_LN2_LO = 32'hB5BF_BE8E;
    localparam logic [31:0] F_C0     = 32'h3AB4_A000;
    localparam logic [31:0] F_C1     = 32'h3C09_2F6E;
    localparam logic [31:0] F_C2     = 32'h3D2A_ADAD;
    localparam logic [31:0] F_C3     = 32'h3E2A_AA28;
    localparam logic [31:0] F_C4     = 32'h3EFF_FFFB;

    localparam logic [31:0] F_POS_INF    = 32'h7F80_0000;
    localparam logic [31:0] F_QUIET_BIT  = 32'h0040_0000;
    localparam logic [30:0] F_ABS_104    = 31'h42D0_0000;
    localparam logic [31:0] F_SCALE_BASE = 32'h7F00_0000;
    localparam logic [31:0] F_SCALE_ADJ  = 32'h8300_0000;

    // fused multiply-add units in the chain and stages in each
    localparam int unsigned N_FMA     = 12;
    localparam int unsigned FMA_DEPTH = 4;
    // accept edge to the edge at which the result strobe is sampled
    localparam int unsigned FEXP_LAT  = N_FMA * FMA_DEPTH + 1;

    // per-transaction data that rides alongside the arithmetic
    typedef struct packed {
        logic        bypass;    // special operand, result already known
        logic [31:0] byp_val;
        logic [31:0] a;         // operand (zeroed when bypassed)
        logic [31:0] j;         // rounded a/ln2 as float
        logic [8:0]  i;         // the same as a signed integer
        logic [31:0] f;         // reduced argument
        logic [31:0] tb;        // second scale factor
    } t_side;

endpackage

@@ rtl/core/fexp_fma.sv @@
// four-stage binary32 fused multiply-add, one rounding to nearest even
// depends on fexp_pkg for the side-data type

module fexp_fma (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [31:0]      i_x,
    input  logic [31:0]      i_y,
    input  logic [31:0]      i_z,
    input  fexp_pkg::t_side  i_side,
    output logic             o_vld,
    output logic [31:0]      o_res,
    output fexp_pkg::t_side  o_side
);

    // stage 1: multiply, align addend
    logic [7:0]  ex, ey, ez;
    logic [23:0] mx, my, mz;
    logic [9:0]  exy;
    logic [10:0] dd;
    logic        d_neg, d_clamp;
    logic [75:0] n_b;
    logic [10:0] n_fe;

    always_comb begin
        ex = (i_x[30:23] == 8'd0) ? 8'd1 : i_x[30:23];
        ey = (i_y[30:23] == 8'd0) ? 8'd1 : i_y[30:23];
        ez = (i_z[30:23] == 8'd0) ? 8'd1 : i_z[30:23];
        mx = {|i_x[30:23], i_x[22:0]};
        my = {|i_y[30:23], i_y[22:0]};
        mz = {|i_z[30:23], i_z[22:0]};
        exy = {2'b00, ex} + {2'b00, ey};
        dd = {3'b000, ez} + 11'd150 - {1'b0, exy};
        d_neg = dd[10];
        d_clamp = !dd[10] && (dd[9:0] > 10'd50);
        if (d_neg) begin
            n_b = {75'd0, |mz};
        end else if (d_clamp) begin
            n_b = {mz, 52'd0};
        end else begin
            n_b = {52'd0, mz} << (7'(dd[5:0]) + 7'd2);
        end
        n_fe = d_clamp ? ({3'b000, ez} - 11'd202) : ({1'b0, exy} - 11'd302);
    end

    logic            r1_vld;
    logic [47:0]     r1_p;
    logic [75:0]     r1_b;
    logic            r1_clamp;
    logic [10:0]     r1_fe;
    logic            r1_sp, r1_sz;
    fexp_pkg::t_side r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_p     <= mx * my;
        r1_b     <= n_b;
        r1_clamp <= d_clamp;
        r1_fe    <= n_fe;
        r1_sp    <= i_x[31] ^ i_y[31];
        r1_sz    <= i_z[31];
        r1_side  <= i_side;
    end

    // stage 2: add or subtract magnitudes
    logic [75:0] a_fr;
    logic [76:0] sum_ab, dif_ab, dif_ba, n_m;
    logic        n_sign;

    always_comb begin
        a_fr = r1_clamp ? {75'd0, |r1_p} : {26'd0, r1_p, 2'b00};
        sum_ab = {1'b0, a_fr} + {1'b0, r1_b};
        dif_ab = {1'b0, a_fr} - {1'b0, r1_b};
        dif_ba = {1'b0, r1_b} - {1'b0, a_fr};
        if (r1_sp == r1_sz) begin
            n_m = sum_ab;
            n_sign = r1_sp;
        end else if (dif_ab[76]) begin
            n_m = dif_ba;
            n_sign = r1_sz;
        end else begin
            n_m = dif_ab;
            n_sign = (dif_ab == 77'd0) ? 1'b0 : r1_sp;
        end
    end

    logic            r2_vld;
    logic [76:0]     r2_m;
    logic [10:0]     r2_fe;
    logic            r2_sign;
    fexp_pkg::t_side r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_m    <= n_m;
        r2_fe   <= r1_fe;
        r2_sign <= n_sign;
        r2_side <= r1_side;
    end

    // stage 3: leading-one search, shift amount and exponent
    logic [6:0]  lead;
    logic [11:0] e_chk, sub_sh;
    logic        is_norm;
    logic [6:0]  n_sh;
    logic [9:0]  n_ebase;

    always_comb begin
        lead = 7'd0;
        for (int k = 0; k < 77; k++) begin
            if (r2_m[k]) begin
                lead = 7'(k);
            end
        end
        e_chk = {5'd0, lead} + {r2_fe[10], r2_fe};
        is_norm = $signed(e_chk) >= -12'sd126;
        sub_sh = {r2_fe[10], r2_fe} + 12'd202;
        if (is_norm) begin
            n_sh = 7'd76 - lead;
            n_ebase = 10'(e_chk + 12'd126);
        end else begin
            n_sh = sub_sh[11] ? 7'd0 : ((sub_sh > 12'd76) ? 7'd76 : sub_sh[6:0]);
            n_ebase = 10'd0;
        end
    end

    logic            r3_vld;
    logic [76:0]     r3_m;
    logic [6:0]      r3_sh;
    logic [9:0]      r3_ebase;
    logic            r3_sign, r3_zero;
    fexp_pkg::t_side r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_m     <= r2_m;
        r3_sh    <= n_sh;
        r3_ebase <= n_ebase;
        r3_sign  <= r2_sign;
        r3_zero  <= (r2_m == 77'd0);
        r3_side  <= r2_side;
    end

    // stage 4: normalize, round to nearest even, pack
    logic [76:0] nrm;
    logic [23:0] mant;
    logic        rnd_up;
    logic [24:0] mant_r;
    logic [33:0] packed_v;
    logic [31:0] n_res;

    always_comb begin
        nrm = r3_m << r3_sh;
        mant = nrm[76:53];
        rnd_up = nrm[52] & ((|nrm[51:0]) | mant[0]);
        mant_r = {1'b0, mant} + {24'd0, rnd_up};
        packed_v = {1'b0, r3_ebase, 23'd0} + {9'd0, mant_r};
        if (r3_zero) begin
            n_res = {r3_sign, 31'd0};
        end else if (packed_v >= {2'b00, fexp_pkg::F_POS_INF}) begin
            n_res = {r3_sign, fexp_pkg::F_POS_INF[30:0]};
        end else begin
            n_res = {r3_sign, packed_v[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r3_vld;
        end
        o_res  <= n_res;
        o_side <= r3_side;
    end

endmodule

@@ rtl/core/float32_exp_with_overflow_core.sv @@
// top level of the single-precision exp pipeline
// depends on fexp_pkg and fexp_fma

// Computes an approximation of e^a for one IEEE single-precision operand per
// cycle. A transaction is taken at every clock edge where start is high and
// busy is low; busy is high only while reset is held. The result appears on
// o_result_bits with o_done high for exactly one cycle, in the order in which the
// transactions were taken; the receiver cannot stall it.
// The pipeline is the chain of twelve four-stage fused multiply-add
// units (two for range rounding, two for the ln2 reduction, six for the
// polynomial, two for the power-of-two scaling) plus one output register.
// NaN operands come back with the quiet bit set; for |a| >= 104 the result is
// +infinity for positive a and zero for negative a. Results that overflow
// round to +infinity and tiny results round into the subnormal range.

module float32_exp_with_overflow_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand_bits,
    output logic        o_done,
    output logic [31:0] o_result_bits
);

    localparam int unsigned NU = fexp_pkg::N_FMA;

    logic            u_vld_in  [NU];
    logic [31:0]     u_x       [NU];
    logic [31:0]     u_y       [NU];
    logic [31:0]     u_z       [NU];
    fexp_pkg::t_side u_side_in [NU];
    logic            u_vld     [NU];
    logic [31:0]     u_res     [NU];
    fexp_pkg::t_side u_side    [NU];

    assign busy = !i_rst_n;

    // special operand decode at the front
    logic [30:0]     mag;
    logic            is_nan, is_big;
    fexp_pkg::t_side side0;

    always_comb begin
        mag = i_operand_bits[30:0];
        is_nan = mag > fexp_pkg::F_POS_INF[30:0];
        is_big = mag >= fexp_pkg::F_ABS_104;
        side0 = '0;
        side0.bypass = is_nan | is_big;
        if (is_nan) begin
            side0.byp_val = i_operand_bits | fexp_pkg::F_QUIET_BIT;
        end else begin
            side0.byp_val = i_operand_bits[31] ? 32'd0 : fexp_pkg::F_POS_INF;
        end
        side0.a = side0.bypass ? 32'd0 : i_operand_bits;
    end

    // j as float -> signed integer, plus the second scale factor
    logic [31:0]     jf;
    logic [7:0]      j_shr;
    logic [7:0]      j_mag;
    logic [8:0]      j_int;
    logic [31:0]     j_ext, ia;
    fexp_pkg::t_side side2;

    always_comb begin
        jf = u_res[1];
        j_shr = (jf[30:23] >= 8'd150) ? 8'd0 : (8'd150 - jf[30:23]);
        if (jf[30:23] < 8'd127) begin
            j_mag = 8'd0;
        end else begin
            j_mag = 8'({1'b1, jf[22:0]} >> j_shr);
        end
        j_int = jf[31] ? (9'd0 - {1'b0, j_mag}) : {1'b0, j_mag};
        j_ext = {{23{j_int[8]}}, j_int};
        ia = ($signed(j_int) > 9'sd0) ? 32'd0 : fexp_pkg::F_SCALE_ADJ;
        side2 = u_side[1];
        side2.j = jf;
        side2.i = j_int;
        side2.tb = (j_ext << 23) - ia;
    end

    // first scale factor from the sign of i; reduced argument f into the side data
    logic [31:0]     s_bits;
    fexp_pkg::t_side side4;

    always_comb begin
        s_bits = ($signed(u_side[9].i) > 9'sd0) ? fexp_pkg::F_SCALE_BASE
                                                 : (fexp_pkg::F_SCALE_BASE
                                                    + fexp_pkg::F_SCALE_ADJ);
        side4 = u_side[3];
        side4.f = u_res[3];
    end

    // operand routing between units
    always_comb begin
        u_vld_in[0] = start && !busy;
        for (int k = 1; k < NU; k++) begin
            u_vld_in[k] = u_vld[k-1];
            u_side_in[k] = u_side[k-1];
        end
        u_side_in[0] = side0;
        u_side_in[2] = side2;
        u_side_in[4] = side4;

        // t = log2e * a + bias, j = t - bias
        u_x[0] = fexp_pkg::F_LOG2E;  u_y[0] = side0.a;              u_z[0] = fexp_pkg::F_BIAS;
        u_x[1] = u_res[0];           u_y[1] = fexp_pkg::F_ONE;      u_z[1] = fexp_pkg::F_NBIAS;
        // two-part ln2 reduction
        u_x[2] = jf;                 u_y[2] = fexp_pkg::F_LN2_HI;   u_z[2] = u_side[1].a;
        u_x[3] = u_side[2].j;        u_y[3] = fexp_pkg::F_LN2_LO;   u_z[3] = u_res[2];
        // horner polynomial in f
        u_x[4] = fexp_pkg::F_C0;     u_y[4] = u_res[3];             u_z[4] = fexp_pkg::F_C1;
        u_x[5] = u_res[4];           u_y[5] = u_side[4].f;          u_z[5] = fexp_pkg::F_C2;
        u_x[6] = u_res[5];           u_y[6] = u_side[5].f;          u_z[6] = fexp_pkg::F_C3;
        u_x[7] = u_res[6];           u_y[7] = u_side[6].f;          u_z[7] = fexp_pkg::F_C4;
        u_x[8] = u_res[7];           u_y[8] = u_side[7].f;          u_z[8] = fexp_pkg::F_ONE;
        u_x[9] = u_res[8];           u_y[9] = u_side[8].f;          u_z[9] = fexp_pkg::F_ONE;
        // two-step scaling by 2^i
        u_x[10] = u_res[9];          u_y[10] = s_bits;              u_z[10] = fexp_pkg::F_ZERO;
        u_x[11] = u_res[10];         u_y[11] = u_side[10].tb;       u_z[11] = fexp_pkg::F_ZERO;
    end

    for (genvar g = 0; g < NU; g++) begin : g_fma
        fexp_fma u_fma (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (u_vld_in[g]),
            .i_x    (u_x[g]),
            .i_y    (u_y[g]),
            .i_z    (u_z[g]),
            .i_side (u_side_in[g]),
            .o_vld  (u_vld[g]),
            .o_res  (u_res[g]),
            .o_side (u_side[g])
        );
    end

    // output register, special results replace the computed value
    logic        r_done;
    logic [31:0] r_result;
    logic [31:0] n_result;

    assign n_result = u_side[NU-1].bypass ? u_side[NU-1].byp_val : u_res[NU-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= u_vld[NU-1];
        end
        r_result <= n_result;
    end

    assign o_done        = r_done;
    assign o_result_bits = r_result;

endmodule

@@ rtl/core/fexp_chk.sv @@
// port-level checker for the exp pipeline, bound to the top level
// depends on fexp_pkg for the pipeline latency and the special-operand constants

module fexp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] i_operand_bits,
    input logic        o_done,
    input logic [31:0] o_result_bits
);

    localparam int unsigned LAT = fexp_pkg::FEXP_LAT;

    // every transaction yields its strobe after the fixed latency
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("missing result strobe");

    // no strobe without a transaction at the matching edge
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without transaction");

    // nan passes through quieted
    a_nan_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_operand_bits[30:0] > fexp_pkg::F_POS_INF[30:0], LAT))
        |-> (o_result_bits == ($past(i_operand_bits, LAT) | fexp_pkg::F_QUIET_BIT)))
        else $error("nan not passed through");

    // large magnitude saturates by sign
    a_big_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_operand_bits[30:0] >= fexp_pkg::F_ABS_104, LAT)
         && $past(i_operand_bits[30:0] <= fexp_pkg::F_POS_INF[30:0], LAT))
        |-> (o_result_bits == ($past(i_operand_bits[31], LAT) ? 32'd0
                                                              : fexp_pkg::F_POS_INF)))
        else $error("large operand not saturated");

endmodule

bind float32_exp_with_overflow_core fexp_chk u_fexp_chk (.*);

@@ dv/fexp_checker.sv @@
// checker for the single-precision exp core: predicts each transaction
// and compares results in order; depends on fexp_pkg only
`timescale 1ns / 100ps

module fexp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_operand_bits,
    input  logic        o_done,
    input  logic [31:0] o_result_bits,
    output int          fail_count,
    output int          pending
);

    logic [31:0] exp_results_q[$];

    // binary32 pattern to real, exact
    function automatic real f32_to_real(logic [31:0] b);
        int   ex;
        real  mag;
        ex  = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        mag = real'({b[30:23] != 0, b[22:0]}) * (2.0 ** (ex - 150));
        return b[31] ? -mag : mag;
    endfunction

    // real to binary32, round to nearest even, overflow to infinity
    function automatic logic [31:0] real_to_f32(real d);
        logic [63:0] db;
        logic [52:0] sig;
        logic [52:0] keep;
        logic [53:0] rest;
        logic [53:0] half;
        logic [31:0] mag;
        int          fe;
        int          sh;
        logic        inc;
        db = $realtobits(d);
        if (db[62:52] == 0)
            return {db[63], 31'd0};
        sig = {1'b1, db[51:0]};
        fe  = int'(db[62:52]) - 1023 + 127;
        if (fe >= 255)
            return {db[63], 31'h7F80_0000};
        sh = (fe >= 1) ? 29 : 29 + 1 - fe;
        if (sh > 54)
            return {db[63], 31'd0};
        keep = sig >> sh;
        rest = {1'b0, sig} & ((54'd1 << sh) - 1);
        half = 54'd1 << (sh - 1);
        inc  = (rest > half) || (rest == half && keep[0]);
        if (fe >= 1)
            mag = (32'(fe) << 23) + 32'(keep[22:0]) + 32'(inc);
        else
            mag = 32'(keep) + 32'(inc);
        if (mag >= 32'h7F80_0000)
            mag = 32'h7F80_0000;
        return {db[63], mag[30:0]};
    endfunction

    // x*y+z with a single binary32 rounding (round to odd in double first)
    function automatic logic [31:0] fused_mac(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z);
        real         p;
        real         zd;
        real         s;
        real         v;
        real         e;
        logic [63:0] sb;
        p  = f32_to_real(x) * f32_to_real(y);
        zd = f32_to_real(z);
        s  = p + zd;
        v  = s - p;
        e  = (p - (s - v)) + (zd - v);
        if (e != 0.0) begin
            sb = $realtobits(s);
            if (!sb[0]) begin
                sb = ((e > 0.0) == (s > 0.0)) ? sb + 1 : sb - 1;
                s  = $bitstoreal(sb);
            end
        end
        return real_to_f32(s);
    endfunction

    function automatic logic [31:0] mul_f32(logic [31:0] x, logic [31:0] y);
        return real_to_f32(f32_to_real(x) * f32_to_real(y));
    endfunction

    function automatic logic [31:0] exp_predict(logic [31:0] a);
        logic [31:0] j;
        logic [31:0] f;
        logic [31:0] r;
        logic [31:0] adj;
        int          n;
        if (a[30:0] > fexp_pkg::F_POS_INF[30:0])
            return a | fexp_pkg::F_QUIET_BIT;
        if (a[30:0] >= fexp_pkg::F_ABS_104)
            return a[31] ? fexp_pkg::F_ZERO : fexp_pkg::F_POS_INF;
        j = fused_mac(fused_mac(fexp_pkg::F_LOG2E, a, fexp_pkg::F_BIAS),
                      fexp_pkg::F_ONE, fexp_pkg::F_NBIAS);
        f = fused_mac(j, fexp_pkg::F_LN2_HI, a);
        f = fused_mac(j, fexp_pkg::F_LN2_LO, f);
        n = $rtoi(f32_to_real(j));
        r = fexp_pkg::F_C0;
        r = fused_mac(r, f, fexp_pkg::F_C1);
        r = fused_mac(r, f, fexp_pkg::F_C2);
        r = fused_mac(r, f, fexp_pkg::F_C3);
        r = fused_mac(r, f, fexp_pkg::F_C4);
        r = fused_mac(r, f, fexp_pkg::F_ONE);
        r = fused_mac(r, f, fexp_pkg::F_ONE);
        adj = (n > 0) ? 32'd0 : fexp_pkg::F_SCALE_ADJ;
        r = mul_f32(r, fexp_pkg::F_SCALE_BASE + adj);
        r = mul_f32(r, (32'(n) << 23) - adj);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
    end

    assign pending = exp_results_q.size();

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            exp_results_q.push_back(exp_predict(i_operand_bits));
        if (i_rst_n && o_done) begin
            if (exp_results_q.size() == 0)
                report_mismatch($sformatf("unexpected result %h", o_result_bits));
            else if (o_result_bits !== exp_results_q[0]) begin
                report_mismatch($sformatf("result %h, expected %h",
                                          o_result_bits, exp_results_q[0]));
                void'(exp_results_q.pop_front());
            end else
                void'(exp_results_q.pop_front());
        end
    end

endmodule

@@ dv/tb.sv @@
// top of the exp core testbench: clock, reset, operand stimulus, verdict
// depends on fexp_pkg, fexp_checker and the core itself
`timescale 1ns / 100ps

module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_operand_bits;
    logic        o_done;
    logic [31:0] o_result_bits;
    int          fail_count;
    int          pending;
    bit          no_gaps;

    float32_exp_with_overflow_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operand_bits (i_operand_bits),
        .o_done         (o_done),
        .o_result_bits  (o_result_bits)
    );

    fexp_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operand_bits (i_operand_bits),
        .o_done         (o_done),
        .o_result_bits  (o_result_bits),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one transaction: random idle cycles first unless no_gaps is set, then hold start until taken
    task automatic send_operand(logic [31:0] v);
        while (!no_gaps && $urandom_range(99) < 31) begin
            start <= 1'b0;
            i_operand_bits <= $urandom;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operand_bits <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // mostly in-range operands, sweeping every exponent that matters,
    // with some fully random patterns for specials and huge values
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0, 1, 2: ;
            3, 4: v[30:23] = 8'h85;                            // near overflow/underflow edge
            default: v[30:23] = 8'($urandom_range(8'h60, 8'h85));
        endcase
        return v;
    endfunction

    localparam logic [31:0] DIRECTED [24] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h42D0_0000, 32'hC2D0_0000, 32'h42CF_FFFF, 32'hC2CF_FFFF,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
        32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
        32'h8000_0001, 32'h42B1_7218, 32'h42B2_0000, 32'h42C8_0000,
        32'hC2AE_A8F6, 32'hC2B4_0000, 32'hC2C8_0000, 32'h3F00_0000
    };

    initial begin
        start          = 1'b0;
        i_operand_bits = '0;
        i_rst_n        = 1'b0;
        no_gaps        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, specials, and both overflow/underflow bands
        foreach (DIRECTED[k])
            send_operand(DIRECTED[k]);

        // hold off until the pipeline has drained
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 1300; n++) begin
            no_gaps = (n >= 400 && n < 600);
            send_operand(pick_operand());
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (fexp_pkg::FEXP_LAT + 5) @(posedge i_clk);
        if (fail_count == 0)
            $display("float32_exp_with_overflow_core regression: pass");
        else
            $display("float32_exp_with_overflow_core regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("float32_exp_with_overflow_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/fexp_pkg.sv
rtl/core/fexp_fma.sv
rtl/core/float32_exp_with_overflow_core.sv
rtl/core/fexp_chk.sv
dv/fexp_checker.sv
dv/tb.sv
